// ===== rtl/core/ted_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text encoding detector package
// Shared types, constants and mark tables for the encoding detector core.
// ----------------------------------------------------------------------------
package ted_pkg;

    // Result codes for the detected encoding.
    typedef enum logic [2:0] {
        KIND_UTF8     = 3'd0,
        KIND_UTF8_BOM = 3'd1,
        KIND_UTF16LE  = 3'd2,
        KIND_UTF16BE  = 3'd3,
        KIND_ANSI     = 3'd4
    } encoding_kind_t;

    // Byte order marks, one byte per position.
    localparam logic [7:0] MARK_UTF8 [3] = '{8'hEF, 8'hBB, 8'hBF};
    localparam logic [7:0] MARK_LE   [2] = '{8'hFF, 8'hFE};
    localparam logic [7:0] MARK_BE   [2] = '{8'hFE, 8'hFF};

    // Bit positions in the mark match flags.
    localparam int FLAG_UTF8 = 0;
    localparam int FLAG_LE   = 1;
    localparam int FLAG_BE   = 2;

    // Code point limits used by the strict UTF-8 check.
    localparam logic [20:0] CP_MIN_TWO   = 21'h00080;
    localparam logic [20:0] CP_MIN_THREE = 21'h00800;
    localparam logic [20:0] CP_MIN_FOUR  = 21'h10000;
    localparam logic [20:0] CP_MAX       = 21'h10FFFF;
    localparam logic [20:0] SURR_LO      = 21'h0D800;
    localparam logic [20:0] SURR_HI      = 21'h0DFFF;

    // Running state carried from one byte to the next.
    typedef struct packed {
        logic [1:0]  byte_position;
        logic [2:0]  prefix_match_flags;
        logic        utf8_still_valid;
        logic [1:0]  continuations_pending;
        logic [20:0] partial_code_point;
        logic [1:0]  sequence_length_class;
    } ted_state_t;

    localparam ted_state_t STATE_RESET = '{
        byte_position:         2'd0,
        prefix_match_flags:    3'b111,
        utf8_still_valid:      1'b1,
        continuations_pending: 2'd0,
        partial_code_point:    21'd0,
        sequence_length_class: 2'd0
    };

    // One classification result.
    typedef struct packed {
        encoding_kind_t encoding_kind;
        logic [1:0]     mark_length;
    } ted_result_t;

endpackage

// ===== rtl/core/ted_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text encoding detector channels
// Valid/ready channels for incoming bytes and outgoing results.
// ----------------------------------------------------------------------------
interface ted_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ted_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] encoding_kind;
    logic [1:0] mark_length;

    modport source (output valid, output encoding_kind, output mark_length, input ready);
    modport sink   (input valid, input encoding_kind, input mark_length, output ready);
endinterface

// ===== rtl/core/ted_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text encoding detector byte decode
// Updates the mark flags and UTF-8 check for one byte and forms the result.
// ----------------------------------------------------------------------------
module ted_decode
(
    input  ted_pkg::ted_state_t  cur_state,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    output ted_pkg::ted_state_t  next_state,
    output ted_pkg::ted_result_t result
);
    import ted_pkg::*;

    ted_state_t  upd;
    logic [20:0] cp_shift;
    logic [20:0] cp_low;

    assign cp_shift = {cur_state.partial_code_point[14:0], data_byte[5:0]};

    always_comb
    begin
        case (cur_state.sequence_length_class)
            2'd1:    cp_low = CP_MIN_TWO;
            2'd2:    cp_low = CP_MIN_THREE;
            default: cp_low = CP_MIN_FOUR;
        endcase
    end

    always_comb
    begin
        upd    = cur_state;
        result = '{encoding_kind: KIND_ANSI, mark_length: 2'd0};

        // Mark checks look only at the first bytes of the buffer.
        if (cur_state.byte_position < 2'd3
            && data_byte != MARK_UTF8[cur_state.byte_position])
        begin
            upd.prefix_match_flags[FLAG_UTF8] = 1'b0;
        end
        if (cur_state.byte_position < 2'd2
            && data_byte != MARK_LE[cur_state.byte_position[0]])
        begin
            upd.prefix_match_flags[FLAG_LE] = 1'b0;
        end
        if (cur_state.byte_position < 2'd2
            && data_byte != MARK_BE[cur_state.byte_position[0]])
        begin
            upd.prefix_match_flags[FLAG_BE] = 1'b0;
        end
        if (cur_state.byte_position < 2'd3)
        begin
            upd.byte_position = cur_state.byte_position + 2'd1;
        end

        // Strict UTF-8 check; once failed, later bytes are ignored.
        if (cur_state.utf8_still_valid)
        begin
            if (cur_state.continuations_pending == 2'd0)
            begin
                if (!data_byte[7])
                begin
                    upd.continuations_pending = 2'd0;
                end
                else if (data_byte[7:5] == 3'b110)
                begin
                    upd.sequence_length_class = 2'd1;
                    upd.continuations_pending = 2'd1;
                    upd.partial_code_point    = {16'd0, data_byte[4:0]};
                end
                else if (data_byte[7:4] == 4'b1110)
                begin
                    upd.sequence_length_class = 2'd2;
                    upd.continuations_pending = 2'd2;
                    upd.partial_code_point    = {17'd0, data_byte[3:0]};
                end
                else if (data_byte[7:3] == 5'b11110)
                begin
                    upd.sequence_length_class = 2'd3;
                    upd.continuations_pending = 2'd3;
                    upd.partial_code_point    = {18'd0, data_byte[2:0]};
                end
                else
                begin
                    upd.utf8_still_valid = 1'b0;
                end
            end
            else if (data_byte[7:6] != 2'b10)
            begin
                upd.utf8_still_valid = 1'b0;
            end
            else
            begin
                upd.continuations_pending = cur_state.continuations_pending - 2'd1;
                if (cur_state.continuations_pending == 2'd1)
                begin
                    if (cp_shift < cp_low || cp_shift > CP_MAX
                        || (cp_shift >= SURR_LO && cp_shift <= SURR_HI))
                    begin
                        upd.utf8_still_valid = 1'b0;
                    end
                    upd.partial_code_point    = 21'd0;
                    upd.sequence_length_class = 2'd0;
                end
                else
                begin
                    upd.partial_code_point = cp_shift;
                end
            end
        end

        // A sequence still open at the final byte fails the check.
        if (last_byte && upd.continuations_pending != 2'd0)
        begin
            upd.utf8_still_valid = 1'b0;
        end

        if (upd.byte_position >= 2'd3 && upd.prefix_match_flags[FLAG_UTF8])
        begin
            result = '{encoding_kind: KIND_UTF8_BOM, mark_length: 2'd3};
        end
        else if (upd.byte_position >= 2'd2 && upd.prefix_match_flags[FLAG_LE])
        begin
            result = '{encoding_kind: KIND_UTF16LE, mark_length: 2'd2};
        end
        else if (upd.byte_position >= 2'd2 && upd.prefix_match_flags[FLAG_BE])
        begin
            result = '{encoding_kind: KIND_UTF16BE, mark_length: 2'd2};
        end
        else if (upd.utf8_still_valid)
        begin
            result = '{encoding_kind: KIND_UTF8, mark_length: 2'd0};
        end

        next_state = last_byte ? STATE_RESET : upd;
    end

endmodule

// ===== rtl/core/ted_result_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text encoding detector result register
// Holds one result until the downstream side takes the request.
// ----------------------------------------------------------------------------
module ted_result_reg
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  ted_pkg::ted_result_t result_in,
    output logic                 free,
    ted_result_if.source         results
);
    import ted_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    ted_result_t data_reg;

    // The register can take a new result when empty or being emptied now.
    assign free       = !valid_reg || results.ready;
    assign valid_next = load || (valid_reg && !results.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result_in;
        end
    end

    assign results.valid         = valid_reg;
    assign results.encoding_kind = data_reg.encoding_kind;
    assign results.mark_length   = data_reg.mark_length;

endmodule

// ===== rtl/core/text_encoding_detector_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text encoding detector core
// Classifies a byte stream as UTF-8 (with or without BOM), UTF-16LE/BE or ANSI.
// ----------------------------------------------------------------------------
// The block takes one byte request per clock cycle and gives one result
// request on the byte that carries last_byte. Each byte passes through a
// single stage: the running state register feeds short decode logic whose
// outcome is written back to the state register and, on the final byte, to
// the result register, so the sustained rate is one byte per cycle and a
// result appears in the cycle after its final byte is accepted. Bytes
// that are not final are accepted even while a result waits downstream; a
// final byte is held back only while the result register is full and not
// being read. After every final byte the state returns to its reset value,
// so the next buffer may follow in the very next cycle. Priority of the
// checks is the UTF-8 mark, then the UTF-16LE mark, then the UTF-16BE mark,
// then strict UTF-8 validation, and otherwise ANSI.
// ----------------------------------------------------------------------------
module text_encoding_detector_core
(
    input  logic         clk,
    input  logic         rst_n,
    ted_byte_if.sink     bytes,
    ted_result_if.source results
);
    import ted_pkg::*;

    ted_state_t  state_reg;
    ted_state_t  state_next;
    ted_state_t  decoded_state;
    ted_result_t decoded_result;
    logic        result_free;
    logic        accept;
    logic        load_result;

    // A byte that closes the buffer needs room in the result register.
    assign bytes.ready = result_free || !bytes.last_byte;
    assign accept      = bytes.valid && bytes.ready;
    assign load_result = accept && bytes.last_byte;
    assign state_next  = accept ? decoded_state : state_reg;

    ted_decode u_decode
    (
        .cur_state  (state_reg),
        .data_byte  (bytes.data_byte),
        .last_byte  (bytes.last_byte),
        .next_state (decoded_state),
        .result     (decoded_result)
    );

    // The running state is control state and is set to STATE_RESET by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    ted_result_reg u_result_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load_result),
        .result_in (decoded_result),
        .free      (result_free),
        .results   (results)
    );

endmodule
